### hw/rtl/laser_scan_polar_to_cartesian_macros.svh
// Assertion macros shared by the laser scan to Cartesian point converter.
`ifndef LASER_SCAN_POLAR_TO_CARTESIAN_MACROS_SVH
`define LASER_SCAN_POLAR_TO_CARTESIAN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSPC_ASSERT_SAME(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSPC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### hw/rtl/lspc_pkg.sv
// Shared types, register indexes and the arctangent table of the point converter.
package lspc_pkg;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_RANGE       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_RANGE       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_ANGLE     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BEAM_INCREMENT  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECIMATION_STEP = 3'd4;

   localparam logic [29:0] GAIN_Q30 = 30'd652032874;

   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   typedef struct packed {
      logic valid;
      logic flip;
      logic first;
   } ctl_type;

   function automatic logic [31:0] atan_value(input logic [4:0] idx);
      logic [31:0] val;
      begin
         case (idx)
            5'd0: val = 32'h20000000;
            5'd1: val = 32'h12E4051E;
            5'd2: val = 32'h09FB385B;
            5'd3: val = 32'h051111D4;
            5'd4: val = 32'h028B0D43;
            5'd5: val = 32'h0145D7E1;
            5'd6: val = 32'h00A2F61E;
            5'd7: val = 32'h00517C55;
            5'd8: val = 32'h0028BE53;
            5'd9: val = 32'h00145F2F;
            5'd10: val = 32'h000A2F98;
            5'd11: val = 32'h000517CC;
            5'd12: val = 32'h00028BE6;
            5'd13: val = 32'h000145F3;
            5'd14: val = 32'h0000A2FA;
            5'd15: val = 32'h0000517D;
            5'd16: val = 32'h000028BE;
            5'd17: val = 32'h0000145F;
            5'd18: val = 32'h00000A30;
            5'd19: val = 32'h00000518;
            5'd20: val = 32'h0000028C;
            5'd21: val = 32'h00000146;
            5'd22: val = 32'h000000A3;
            5'd23: val = 32'h00000051;
            5'd24: val = 32'h00000029;
            5'd25: val = 32'h00000014;
            5'd26: val = 32'h0000000A;
            5'd27: val = 32'h00000005;
            5'd28: val = 32'h00000003;
            5'd29: val = 32'h00000001;
            5'd30: val = 32'h00000001;
            default: val = 32'h00000000;
         endcase
         return val;
      end
   endfunction

endpackage

### hw/rtl/lspc_front.sv
// Configuration registers, beam angle accumulator, decimation and range window.
module lspc_front #(
   parameter int RANGE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lspc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                         csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [RANGE_BITS-1:0]               req_range_mm,
   input  logic                                req_range_invalid,
   input  logic                                req_scan_start,
   input  logic                                dn_en,
   output lspc_pkg::ctl_type                   dn_ctl,
   output logic [RANGE_BITS-1:0]               dn_range,
   output logic [31:0]                         dn_angle
);

   logic [15:0] min_range_ff;
   logic [15:0] max_range_ff;
   logic [31:0] start_angle_ff;
   logic [31:0] beam_increment_ff;
   logic [7:0]  decimation_step_ff;
   logic        settle_ff;

   logic [31:0] inc_step_ff;
   logic [31:0] inc_step_in;
   logic [39:0] inc_product;
   logic [7:0]  step_n;

   logic [7:0]  beam_phase_ff;
   logic [7:0]  beam_phase_in;
   logic [31:0] beam_angle_ff;
   logic [31:0] beam_angle_in;
   logic        first_pending_ff;
   logic        first_pending_in;

   lspc_pkg::ctl_type     a_ctl_ff;
   lspc_pkg::ctl_type     a_ctl_in;
   logic [RANGE_BITS-1:0] a_range_ff;
   logic [31:0]           a_angle_ff;

   logic                  load_a;
   logic                  accept;
   logic [31:0]           angle_eff;
   logic [7:0]            phase_eff;
   logic                  first_eff;
   logic                  considered;
   logic                  keep;
   logic [8:0]            phase_next;
   logic [RANGE_BITS-1:0] lo;
   logic [RANGE_BITS-1:0] hi;

   assign step_n      = (decimation_step_ff == 8'd0) ? 8'd1 : decimation_step_ff;
   assign inc_product = beam_increment_ff * step_n;
   assign inc_step_in = inc_product[31:0];

   assign lo = RANGE_BITS'(min_range_ff);
   assign hi = RANGE_BITS'(max_range_ff);

   assign load_a    = !a_ctl_ff.valid || dn_en;
   assign req_ready = load_a && !settle_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      angle_eff  = req_scan_start ? start_angle_ff : beam_angle_ff;
      phase_eff  = req_scan_start ? 8'd0 : beam_phase_ff;
      first_eff  = req_scan_start ? 1'b1 : first_pending_ff;
      considered = (phase_eff == 8'd0);
      keep       = considered && !req_range_invalid && (lo <= req_range_mm)
                   && (req_range_mm <= hi);
      phase_next = {1'b0, phase_eff} + 9'd1;
      if (phase_next >= {1'b0, step_n}) begin
         beam_phase_in = 8'd0;
      end else begin
         beam_phase_in = phase_next[7:0];
      end
      beam_angle_in    = considered ? (angle_eff + inc_step_ff) : angle_eff;
      first_pending_in = keep ? 1'b0 : first_eff;
      a_ctl_in.valid   = accept && keep;
      a_ctl_in.flip    = 1'b0;
      a_ctl_in.first   = first_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff       <= 16'd0;
         max_range_ff       <= 16'hFFFF;
         start_angle_ff     <= lspc_pkg::HALF_TURN;
         beam_increment_ff  <= 32'd11930465;
         decimation_step_ff <= 8'd1;
         settle_ff          <= 1'b1;
      end else begin
         settle_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_index)
               lspc_pkg::CSR_MIN_RANGE:       min_range_ff       <= csr_wdata[15:0];
               lspc_pkg::CSR_MAX_RANGE:       max_range_ff       <= csr_wdata[15:0];
               lspc_pkg::CSR_START_ANGLE:     start_angle_ff     <= csr_wdata;
               lspc_pkg::CSR_BEAM_INCREMENT:  beam_increment_ff  <= csr_wdata;
               lspc_pkg::CSR_DECIMATION_STEP: decimation_step_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      inc_step_ff <= inc_step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_phase_ff    <= 8'd0;
         beam_angle_ff    <= lspc_pkg::HALF_TURN;
         first_pending_ff <= 1'b1;
         a_ctl_ff         <= '0;
      end else begin
         if (accept) begin
            beam_phase_ff    <= beam_phase_in;
            beam_angle_ff    <= beam_angle_in;
            first_pending_ff <= first_pending_in;
         end
         if (load_a) begin
            a_ctl_ff <= a_ctl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_range_ff <= req_range_mm;
         a_angle_ff <= angle_eff;
      end
   end

   assign dn_ctl   = a_ctl_ff;
   assign dn_range = a_range_ff;
   assign dn_angle = a_angle_ff;

endmodule

### hw/rtl/lspc_prep.sv
// Gain scaling of the range and half-turn folding of the angle before rotation.
module lspc_prep #(
   parameter int RANGE_BITS = 16,
   parameter int W          = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   dn_en,
   output logic                   up_en,
   input  lspc_pkg::ctl_type      up_ctl,
   input  logic [RANGE_BITS-1:0]  up_range,
   input  logic [31:0]            up_angle,
   output lspc_pkg::ctl_type      dn_ctl,
   output logic signed [W-1:0]    dn_x,
   output logic signed [31:0]     dn_z
);

   lspc_pkg::ctl_type     ctl_ff;
   lspc_pkg::ctl_type     ctl_in;
   logic signed [W-1:0]   x_ff;
   logic signed [31:0]    z_ff;
   logic [RANGE_BITS+29:0] product;
   logic                  flip;
   logic                  load;

   assign load    = !ctl_ff.valid || dn_en;
   assign up_en   = load;
   assign product = up_range * lspc_pkg::GAIN_Q30;
   assign flip    = (up_angle[31:30] == 2'b01) || (up_angle[31:30] == 2'b10);

   always_comb begin
      ctl_in      = up_ctl;
      ctl_in.flip = flip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= W'(product);
         z_ff <= flip ? (up_angle ^ lspc_pkg::HALF_TURN) : up_angle;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_x   = x_ff;
   assign dn_z   = z_ff;

endmodule

### hw/rtl/lspc_cell.sv
// One CORDIC rotation cell with its own pipeline register.
module lspc_cell #(
   parameter int STAGE = 0,
   parameter int W     = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                dn_en,
   output logic                up_en,
   input  lspc_pkg::ctl_type   up_ctl,
   input  logic signed [W-1:0] up_x,
   input  logic signed [W-1:0] up_y,
   input  logic signed [31:0]  up_z,
   output lspc_pkg::ctl_type   dn_ctl,
   output logic signed [W-1:0] dn_x,
   output logic signed [W-1:0] dn_y,
   output logic signed [31:0]  dn_z
);

   lspc_pkg::ctl_type   ctl_ff;
   logic signed [W-1:0] x_ff;
   logic signed [W-1:0] y_ff;
   logic signed [31:0]  z_ff;
   logic signed [W-1:0] x_in;
   logic signed [W-1:0] y_in;
   logic signed [31:0]  z_in;
   logic signed [W-1:0] x_shift;
   logic signed [W-1:0] y_shift;
   logic signed [31:0]  angle_step;
   logic                load;

   assign load       = !ctl_ff.valid || dn_en;
   assign up_en      = load;
   assign x_shift    = up_x >>> STAGE;
   assign y_shift    = up_y >>> STAGE;
   assign angle_step = lspc_pkg::atan_value(5'(STAGE));

   always_comb begin
      if (!up_z[31]) begin
         x_in = up_x - y_shift;
         y_in = up_y + x_shift;
         z_in = up_z - angle_step;
      end else begin
         x_in = up_x + y_shift;
         y_in = up_y - x_shift;
         z_in = up_z + angle_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_x   = x_ff;
   assign dn_y   = y_ff;
   assign dn_z   = z_ff;

endmodule

### hw/rtl/lspc_post.sv
// Sign restore, rounding, saturation and the output word register.
module lspc_post #(
   parameter int RANGE_BITS = 16,
   parameter int W          = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  up_en,
   input  lspc_pkg::ctl_type     up_ctl,
   input  logic signed [W-1:0]   up_x,
   input  logic signed [W-1:0]   up_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RANGE_BITS:0]   rsp_point_x,
   output logic [RANGE_BITS:0]   rsp_point_y,
   output logic                  rsp_first_point
);

   localparam logic signed [W-1:0] LIM   = W'((64'd1 << RANGE_BITS) - 64'd1);
   localparam logic signed [W-1:0] BIAS  = W'(64'd1 << 29);
   localparam logic signed [W-1:0] BIAS1 = W'((64'd1 << 29) + 64'd1);

   logic                  valid_ff;
   logic [RANGE_BITS:0]   x_ff;
   logic [RANGE_BITS:0]   y_ff;
   logic                  first_ff;
   logic [RANGE_BITS:0]   x_in;
   logic [RANGE_BITS:0]   y_in;
   logic                  load;

   function automatic logic [RANGE_BITS:0] finish(input logic signed [W-1:0] v,
                                                   input logic flip);
      logic signed [W-1:0] biased;
      logic signed [W-1:0] shifted;
      logic signed [W-1:0] clipped;
      begin
         biased  = flip ? ((~v) + BIAS1) : (v + BIAS);
         shifted = biased >>> 30;
         if (shifted > LIM) begin
            clipped = LIM;
         end else if (shifted < -LIM) begin
            clipped = -LIM;
         end else begin
            clipped = shifted;
         end
         return clipped[RANGE_BITS:0];
      end
   endfunction

   assign load  = !valid_ff || rsp_ready;
   assign up_en = load;
   assign x_in  = finish(up_x, up_ctl.flip);
   assign y_in  = finish(up_y, up_ctl.flip);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         first_ff <= up_ctl.first;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_point_x     = x_ff;
   assign rsp_point_y     = y_ff;
   assign rsp_first_point = first_ff;

endmodule

### hw/rtl/laser_scan_polar_to_cartesian.sv
// Top level of the laser scan to Cartesian point converter.
// Takes one range sample word per cycle while req_ready is high and returns
// x = r*cos(a), y = r*sin(a) for every kept sample. The edge that accepts a
// sample loads the angle accumulator and range window register. The sample then
// passes the gain multiply and half-turn fold register, a register in each CORDIC
// cell and the rounding into the output register, where the output word becomes
// valid. Each stage stalls only while its own register is full and blocked,
// so empty slots close up behind a waiting output word. Skipped or rejected
// samples produce no word. After a write on the configuration port the input
// is held off in the next cycle while the angle step (increment times
// decimation) is recomputed into its register; the same applies right after
// reset.
`include "laser_scan_polar_to_cartesian_macros.svh"

module laser_scan_polar_to_cartesian #(
   parameter int CORDIC_STAGES = 16,
   parameter int RANGE_BITS    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lspc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]                         csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [RANGE_BITS-1:0]               req_range_mm,
   input  logic                                req_range_invalid,
   input  logic                                req_scan_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [RANGE_BITS:0]                 rsp_point_x,
   output logic [RANGE_BITS:0]                 rsp_point_y,
   output logic                                rsp_first_point
);

   localparam int W = RANGE_BITS + 32;
   localparam logic [RANGE_BITS:0] OUT_MIN = {1'b1, {RANGE_BITS{1'b0}}};

   lspc_pkg::ctl_type     a_ctl;
   logic [RANGE_BITS-1:0] a_range;
   logic [31:0]           a_angle;
   logic                  prep_en;

   lspc_pkg::ctl_type   ctl_chain [0:CORDIC_STAGES];
   logic signed [W-1:0] x_chain   [0:CORDIC_STAGES];
   logic signed [W-1:0] y_chain   [0:CORDIC_STAGES];
   logic signed [31:0]  z_chain   [0:CORDIC_STAGES];
   logic                en_chain  [0:CORDIC_STAGES];

   lspc_front #(
      .RANGE_BITS(RANGE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_range_mm     (req_range_mm),
      .req_range_invalid(req_range_invalid),
      .req_scan_start   (req_scan_start),
      .dn_en            (prep_en),
      .dn_ctl           (a_ctl),
      .dn_range         (a_range),
      .dn_angle         (a_angle)
   );

   lspc_prep #(
      .RANGE_BITS(RANGE_BITS),
      .W         (W)
   ) u_prep (
      .clock   (clock),
      .reset   (reset),
      .dn_en   (en_chain[0]),
      .up_en   (prep_en),
      .up_ctl  (a_ctl),
      .up_range(a_range),
      .up_angle(a_angle),
      .dn_ctl  (ctl_chain[0]),
      .dn_x    (x_chain[0]),
      .dn_z    (z_chain[0])
   );

   assign y_chain[0] = '0;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      lspc_cell #(
         .STAGE(k),
         .W    (W)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .dn_en (en_chain[k+1]),
         .up_en (en_chain[k]),
         .up_ctl(ctl_chain[k]),
         .up_x  (x_chain[k]),
         .up_y  (y_chain[k]),
         .up_z  (z_chain[k]),
         .dn_ctl(ctl_chain[k+1]),
         .dn_x  (x_chain[k+1]),
         .dn_y  (y_chain[k+1]),
         .dn_z  (z_chain[k+1])
      );
   end

   lspc_post #(
      .RANGE_BITS(RANGE_BITS),
      .W         (W)
   ) u_post (
      .clock          (clock),
      .reset          (reset),
      .up_en          (en_chain[CORDIC_STAGES]),
      .up_ctl         (ctl_chain[CORDIC_STAGES]),
      .up_x           (x_chain[CORDIC_STAGES]),
      .up_y           (y_chain[CORDIC_STAGES]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_first_point(rsp_first_point)
   );

   `LSPC_ASSERT_NEXT(a_cfg_settle, clock, reset, csr_we, !req_ready, "input after write")
   `LSPC_ASSERT_SAME(a_sat_x, clock, reset, rsp_valid, rsp_point_x != OUT_MIN, "x saturation")
   `LSPC_ASSERT_SAME(a_sat_y, clock, reset, rsp_valid, rsp_point_y != OUT_MIN, "y saturation")

endmodule
